// ===== hdl/tlpt_pkg.sv =====
// Shared constants, types and helper functions for the two-level page table mapper.
// Used by the controller, the datapath and the top level; depends on nothing else.
package tlpt_pkg;

    // Store geometry.
    localparam int TABLE_FRAMES      = 64;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int REL_W             = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int STORE_AW          = REL_W + IDX_W;

    // Field widths and address layout.
    localparam int FRAME_W    = 20;
    localparam int VA_W       = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int DIR_SHIFT  = 22;
    localparam int ENTRY_W    = FRAME_W + 3;
    localparam int IN_W       = 88;
    localparam int OUT_W      = 40;

    localparam logic [FRAME_W-1:0] RESET_BASE_FRAME = FRAME_W'(32'h0010_0000 >> PAGE_SHIFT);

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [1:0] ST_NO_FRAME = 2'd2;

    // Operation codes carried in the request.
    typedef enum logic [1:0] {
        FUNC_MAP   = 2'd0,
        FUNC_UNMAP = 2'd1,
        FUNC_XLATE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Entry store address source.
    typedef enum logic [1:0] {
        ADDR_CLEAR = 2'd0,
        ADDR_DIR   = 2'd1,
        ADDR_TBL   = 2'd2
    } addr_sel_t;

    // Entry store write data source.
    typedef enum logic [1:0] {
        WR_ZERO      = 2'd0,
        WR_DIR_ENTRY = 2'd1,
        WR_TBL_ENTRY = 2'd2,
        WR_UNMAP     = 2'd3
    } wdata_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_ready;
        logic       mem_en;
        logic       mem_we;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       clr_step;
        logic       alloc;
        logic       tframe_load;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_from_pte;
        logic       out_load;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  in_valid;
        func_t func;
        logic  dir_in;
        logic  nf_in;
        logic  tfr_in;
        logic  pde_present;
        logic  clr_done;
        logic  out_free;
    } dp_sts_t;

    // True when a frame lies inside the table store.
    function automatic logic frame_in_store(input logic [FRAME_W-1:0] frame,
                                            input logic [FRAME_W-1:0] base);
        logic [FRAME_W:0] diff;
        diff = {1'b0, frame} - {1'b0, base};
        return !diff[FRAME_W] && (diff[FRAME_W-1:0] < FRAME_W'(TABLE_FRAMES));
    endfunction

    // Store slot of one entry inside a frame of the store.
    function automatic logic [STORE_AW-1:0] frame_slot(input logic [FRAME_W-1:0] frame,
                                                       input logic [FRAME_W-1:0] base,
                                                       input logic [IDX_W-1:0]   idx);
        logic [FRAME_W-1:0] rel;
        rel = frame - base;
        return {rel[REL_W-1:0], idx};
    endfunction

    // Stored entry: frame number, user, writable, present (bit 0).
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                      input logic               rw,
                                                      input logic               us);
        return {frame, us, rw, 1'b1};
    endfunction

endpackage

// ===== hdl/tlpt_ctrl.sv =====
// Sequencing state machine of the page table mapper.
// Depends on tlpt_pkg; drives the datapath through ctl_cmd_t and reads dp_sts_t.
module tlpt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  tlpt_pkg::dp_sts_t  sts,
    output tlpt_pkg::ctl_cmd_t cmd
);
    import tlpt_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DIR_RD   = 8'b0000_0100,
        S_DIR_EVAL = 8'b0000_1000,
        S_TBL_WR   = 8'b0001_0000,
        S_TBL_RD   = 8'b0010_0000,
        S_TBL_EVAL = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.mem_en    = 1'b1;
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = ADDR_CLEAR;
                cmd.wdata_sel = WR_ZERO;
                cmd.clr_step  = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid) begin
                    state_next = S_DIR_RD;
                end
            end
            S_DIR_RD: begin
                if (sts.func == FUNC_NONE) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_RESP;
                end else if (!sts.dir_in) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OUTSIDE;
                    state_next     = S_RESP;
                end else begin
                    cmd.mem_en   = 1'b1;
                    cmd.addr_sel = ADDR_DIR;
                    state_next   = S_DIR_EVAL;
                end
            end
            S_DIR_EVAL: begin
                if (sts.func == FUNC_MAP) begin
                    if (sts.pde_present) begin
                        cmd.tframe_load = 1'b1;
                        state_next      = S_TBL_WR;
                    end else if (!sts.nf_in) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_NO_FRAME;
                        state_next     = S_RESP;
                    end else begin
                        // Allocate a fresh table and link it in the directory.
                        cmd.mem_en    = 1'b1;
                        cmd.mem_we    = 1'b1;
                        cmd.addr_sel  = ADDR_DIR;
                        cmd.wdata_sel = WR_DIR_ENTRY;
                        cmd.alloc     = 1'b1;
                        state_next    = S_TBL_WR;
                    end
                end else if (sts.pde_present) begin
                    cmd.tframe_load = 1'b1;
                    state_next      = S_TBL_RD;
                end else begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_RESP;
                end
            end
            S_TBL_WR: begin
                cmd.res_set = 1'b1;
                state_next  = S_RESP;
                if (!sts.tfr_in) begin
                    cmd.res_status = ST_OUTSIDE;
                end else begin
                    cmd.res_status = ST_OK;
                    cmd.mem_en     = 1'b1;
                    cmd.mem_we     = 1'b1;
                    cmd.addr_sel   = ADDR_TBL;
                    cmd.wdata_sel  = WR_TBL_ENTRY;
                end
            end
            S_TBL_RD: begin
                if (!sts.tfr_in) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OUTSIDE;
                    state_next     = S_RESP;
                end else begin
                    cmd.mem_en   = 1'b1;
                    cmd.addr_sel = ADDR_TBL;
                    state_next   = S_TBL_EVAL;
                end
            end
            S_TBL_EVAL: begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
                if (sts.func == FUNC_UNMAP) begin
                    cmd.mem_en    = 1'b1;
                    cmd.mem_we    = 1'b1;
                    cmd.addr_sel  = ADDR_TBL;
                    cmd.wdata_sel = WR_UNMAP;
                end else begin
                    cmd.res_from_pte = 1'b1;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/tlpt_dpath.sv =====
// Datapath of the page table mapper: request capture, entry store, allocator,
// base register and result output register. Depends on tlpt_pkg.
module tlpt_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tlpt_pkg::ctl_cmd_t                    cmd,
    output tlpt_pkg::dp_sts_t                     sts,
    input  logic                                  s_tvalid,
    input  logic [tlpt_pkg::IN_W-1:0]             s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tlpt_pkg::OUT_W-1:0]            m_tdata,
    input  logic                                  cfg_valid,
    input  logic [tlpt_pkg::FRAME_W-1:0]          cfg_data
);
    import tlpt_pkg::*;

    // Captured request.
    func_t                func_reg;
    logic [VA_W-1:0]      va_reg;
    logic [FRAME_W-1:0]   dir_reg;
    logic [FRAME_W-1:0]   pa_frame_reg;
    logic                 rw_reg;
    logic                 us_reg;

    // Control state.
    logic [FRAME_W-1:0]   base_reg;
    logic [FRAME_W-1:0]   nf_reg;
    logic [STORE_AW-1:0]  clr_cnt_reg;
    logic                 m_tvalid_reg;

    // Working and result registers.
    logic [FRAME_W-1:0]   tframe_reg;
    logic [ENTRY_W-1:0]   rdata_reg;
    logic [VA_W-1:0]      res_addr_reg;
    logic                 res_present_reg;
    logic [1:0]           res_status_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    // Entry store.
    logic [ENTRY_W-1:0]   mem [STORE_DEPTH];

    logic [STORE_AW-1:0]  mem_addr;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic                 accept;
    logic [VA_W-1:0]      pte_addr;

    assign accept   = s_tvalid && cmd.in_ready;
    assign pte_addr = {rdata_reg[ENTRY_W-1:3], va_reg[PAGE_SHIFT-1:0]};

    // Address and write data selection for the store port.
    always_comb begin
        case (cmd.addr_sel)
            ADDR_DIR: mem_addr = frame_slot(dir_reg, base_reg, va_reg[VA_W-1:DIR_SHIFT]);
            ADDR_TBL: mem_addr = frame_slot(tframe_reg, base_reg,
                                            va_reg[DIR_SHIFT-1:PAGE_SHIFT]);
            default:  mem_addr = clr_cnt_reg;
        endcase
        case (cmd.wdata_sel)
            WR_DIR_ENTRY: mem_wdata = make_entry(nf_reg, rw_reg, us_reg);
            WR_TBL_ENTRY: mem_wdata = make_entry(pa_frame_reg, rw_reg, us_reg);
            WR_UNMAP:     mem_wdata = {rdata_reg[ENTRY_W-1:1], 1'b0};
            default:      mem_wdata = '0;
        endcase
    end

    // Single-port entry store with registered read data.
    always_ff @(posedge aclk) begin
        if (cmd.mem_en) begin
            if (cmd.mem_we) begin
                mem[mem_addr] <= mem_wdata;
            end else begin
                rdata_reg <= mem[mem_addr];
            end
        end
    end

    // Request capture on an accepted input item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= func_t'(s_tdata[1:0]);
            va_reg       <= s_tdata[33:2];
            dir_reg      <= s_tdata[53:34];
            pa_frame_reg <= s_tdata[85:54+PAGE_SHIFT];
            rw_reg       <= s_tdata[86];
            us_reg       <= s_tdata[87];
        end
    end

    // Base register, allocator and clearing counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= RESET_BASE_FRAME;
            nf_reg      <= RESET_BASE_FRAME;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
                nf_reg   <= cfg_data;
            end else if (cmd.alloc) begin
                nf_reg <= nf_reg + FRAME_W'(1);
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + STORE_AW'(1);
            end
        end
    end

    // Table frame of the walk, from the directory entry or the allocator.
    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            tframe_reg <= nf_reg;
        end else if (cmd.tframe_load) begin
            tframe_reg <= rdata_reg[ENTRY_W-1:3];
        end
    end

    // Pending result of the current item.
    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_status_reg  <= cmd.res_status;
            res_addr_reg    <= cmd.res_from_pte ? pte_addr : '0;
            res_present_reg <= cmd.res_from_pte ? rdata_reg[0] : 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {(OUT_W - VA_W - 3)'(0), res_status_reg, res_present_reg,
                            res_addr_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status toward the controller.
    always_comb begin
        sts.in_valid    = s_tvalid;
        sts.func        = func_reg;
        sts.dir_in      = frame_in_store(dir_reg, base_reg);
        sts.nf_in       = frame_in_store(nf_reg, base_reg);
        sts.tfr_in      = frame_in_store(tframe_reg, base_reg);
        sts.pde_present = rdata_reg[0];
        sts.clr_done    = (clr_cnt_reg == STORE_AW'(STORE_DEPTH - 1));
        sts.out_free    = !m_tvalid_reg || m_tready;
    end

endmodule

// ===== hdl/two_level_page_table_mapper.sv =====
// Two-level page table mapper: map, unmap and translate over an internal entry store.
// One item at a time: map, unmap and translate walk the single-port store directory first,
// then table; early exits (out-of-store frame, absent entry, spent allocator) skip steps,
// and the next item is taken only after the result is loaded into the output register;
// a result left waiting holds the next one back.
// Reset (sync, active low) clears all 65536 store entries with s_tready low; cfg is open.
module two_level_page_table_mapper (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: func[1:0], virtual_address[33:2], directory_frame[53:34],
    // physical_address[85:54], writable[86], user_access[87]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tlpt_pkg::IN_W-1:0]      s_tdata,
    // m_tdata: translated_address[31:0], mapping_present[32], status[34:33], zero[39:35]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tlpt_pkg::OUT_W-1:0]     m_tdata,
    // Configuration write: table_region_base_frame.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tlpt_pkg::FRAME_W-1:0]   cfg_data
);
    import tlpt_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    tlpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    tlpt_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = 1'b1;

    // Only one item is in work: after an acceptance the input side closes.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register loaded while occupied");

    // The allocator only hands out frames that lie inside the store.
    a_alloc_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |-> (sts.nf_in && cmd.mem_we))
        else $error("table frame allocated outside the store");

endmodule
